@@ sv/e2q_pkg.sv @@
`default_nettype none
package e2q_pkg;

  // Field widths
  localparam int ANGLE_BITS = 16;
  localparam int OUT_BITS   = 16;

  // Angle in 32-bit turn units, and the rotator datapath
  localparam int TURN_W     = 32;
  localparam int ROT_STEPS  = 30;
  localparam int CORDIC_W   = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

  // Cosine/sine in Q2.15, range -32768..+32768
  localparam int CS_W       = 17;

  // Depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angle_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
    logic signed [OUT_BITS-1:0] quat_w;
  } quat_out_t;

  // Half angles queued for the back end
  typedef struct packed {
    logic signed [TURN_W-1:0] roll_half;
    logic signed [TURN_W-1:0] pitch_half;
    logic signed [TURN_W-1:0] yaw_half;
  } half_set_t;

  // atan(2^-i), 2^32 per full turn
  function automatic logic signed [CORDIC_W-1:0] atan_step(input int unsigned idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/euler_to_quaternion_top.sv @@
`default_nettype none
// Euler angles (roll, pitch, yaw; Z-Y-X order) to unit quaternion. Angles are
// signed binary angles, a full turn being 2^16; the result is x, y, z, w in
// signed Q1.15, rounded and saturated, so +1.0 reads 32767. The block keeps no
// state between beats and takes one beat per clock while in_stall is low. A
// beat is written into a small queue in the cycle it is accepted, then runs a
// fixed pipeline: 30 CORDIC rotation stages per axis (one micro-rotation each),
// a cosine/sine rounding stage, a pair-product stage, a triple-product stage,
// a sum stage and the output register.
// While out_stall holds a result, the whole pipeline freezes and the queue
// keeps taking beats until it is full (FIFO_DEPTH entries), then in_stall rises.
module euler_to_quaternion_top #(
  parameter int FIFO_DEPTH = e2q_pkg::FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire e2q_pkg::angle_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output e2q_pkg::quat_out_t      out_data
);

  logic               push, pop, fifo_full, rd_valid;
  e2q_pkg::half_set_t push_data, rd_data;

  e2q_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  e2q_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (push_data),
    .full     (fifo_full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  e2q_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/e2q_front.sv @@
`default_nettype none
module e2q_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire e2q_pkg::angle_in_t in_data,
  input  wire logic              fifo_full,
  output logic                   push,
  output e2q_pkg::half_set_t     push_data
);

  // Place a binary angle in 32-bit turn units and halve it exactly
  function automatic logic signed [e2q_pkg::TURN_W-1:0] half_turn(
    input logic [e2q_pkg::ANGLE_BITS-1:0] a
  );
    logic [e2q_pkg::TURN_W-1:0] turn;
    turn = {a, {(e2q_pkg::TURN_W - e2q_pkg::ANGLE_BITS){1'b0}}};
    return $signed(turn) >>> 1;
  endfunction

  // Accept a beat whenever the queue has room
  assign in_stall = fifo_full;
  assign push     = in_valid & ~fifo_full;

  assign push_data.roll_half  = half_turn(in_data.roll_angle);
  assign push_data.pitch_half = half_turn(in_data.pitch_angle);
  assign push_data.yaw_half   = half_turn(in_data.yaw_angle);

endmodule
`default_nettype wire

@@ sv/e2q_fifo.sv @@
`default_nettype none
module e2q_fifo #(
  parameter int DEPTH = e2q_pkg::FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire e2q_pkg::half_set_t wr_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    rd_valid,
  output e2q_pkg::half_set_t      rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  e2q_pkg::half_set_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ sv/e2q_cordic.sv @@
`default_nettype none
module e2q_cordic (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [e2q_pkg::TURN_W-1:0]  half_angle,
  output logic signed [e2q_pkg::CS_W-1:0]         cos_q,
  output logic signed [e2q_pkg::CS_W-1:0]         sin_q
);

  localparam int W = e2q_pkg::CORDIC_W;
  localparam int N = e2q_pkg::ROT_STEPS;
  localparam logic signed [W-1:0] RND_HALF = W'(16384);
  localparam logic signed [W-1:0] CS_MAX   = W'(32768);
  localparam logic signed [W-1:0] CS_MIN   = -CS_MAX;

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic signed [W-1:0] z_r [N];
  logic signed [W-1:0] x_nxt [N];
  logic signed [W-1:0] y_nxt [N];
  logic signed [W-1:0] z_nxt [N];

  // One micro-rotation per stage, shift fixed by the stage index
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = e2q_pkg::CORDIC_K;
      assign yi = '0;
      assign zi = W'(half_angle);
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    assign x_nxt[i] = zi[W-1] ? xi + (yi >>> i) : xi - (yi >>> i);
    assign y_nxt[i] = zi[W-1] ? yi - (xi >>> i) : yi + (xi >>> i);
    assign z_nxt[i] = zi[W-1] ? zi + e2q_pkg::atan_step(i) : zi - e2q_pkg::atan_step(i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
  end

  // Round half up to Q2.15 and clamp to +-1.0
  logic signed [W-1:0] c_sh, s_sh, c_cl, s_cl;
  logic signed [e2q_pkg::CS_W-1:0] cos_nxt, sin_nxt;
  logic signed [e2q_pkg::CS_W-1:0] cos_r, sin_r;

  always_comb begin
    c_sh = (x_r[N-1] + RND_HALF) >>> 15;
    s_sh = (y_r[N-1] + RND_HALF) >>> 15;
    c_cl = (c_sh > CS_MAX) ? CS_MAX : ((c_sh < CS_MIN) ? CS_MIN : c_sh);
    s_cl = (s_sh > CS_MAX) ? CS_MAX : ((s_sh < CS_MIN) ? CS_MIN : s_sh);
    cos_nxt = c_cl[e2q_pkg::CS_W-1:0];
    sin_nxt = s_cl[e2q_pkg::CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule
`default_nettype wire

@@ sv/e2q_back.sv @@
`default_nettype none
module e2q_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_valid,
  input  wire e2q_pkg::half_set_t rd_data,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output e2q_pkg::quat_out_t      out_data
);

  localparam int CW   = e2q_pkg::CS_W;
  localparam int P1W  = 2 * CW;
  localparam int P2W  = P1W + CW;
  localparam int SW   = P2W + 1;
  localparam int OB   = e2q_pkg::OUT_BITS;
  localparam int SH   = 46 - OB;
  localparam int LAT  = e2q_pkg::ROT_STEPS + 1 + 4;
  localparam logic signed [SW-1:0] RND  = SW'(longint'(1) <<< (SH - 1));
  localparam logic signed [SW-1:0] QMAX = SW'((longint'(1) <<< (OB - 1)) - longint'(1));
  localparam logic signed [SW-1:0] QMIN = -QMAX - SW'(1);

  // Whole pipeline moves unless a finished beat is held at the output
  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign en        = ~vld_r[LAT-1] | ~out_stall;
  assign pop       = en & rd_valid;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], rd_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Half-angle cosine and sine, one rotator per axis
  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;

  e2q_cordic u_rot_roll (
    .clk(clk), .en(en), .half_angle(rd_data.roll_half), .cos_q(cr), .sin_q(sr)
  );
  e2q_cordic u_rot_pitch (
    .clk(clk), .en(en), .half_angle(rd_data.pitch_half), .cos_q(cp), .sin_q(sp)
  );
  e2q_cordic u_rot_yaw (
    .clk(clk), .en(en), .half_angle(rd_data.yaw_half), .cos_q(cy), .sin_q(sy)
  );

  // Roll-pitch pair products
  logic signed [P1W-1:0] crcp_r, srsp_r, srcp_r, crsp_r;
  logic signed [CW-1:0]  cy_r, sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      crcp_r <= cr * cp;
      srsp_r <= sr * sp;
      srcp_r <= sr * cp;
      crsp_r <= cr * sp;
      cy_r   <= cy;
      sy_r   <= sy;
    end
  end

  // Triple products with yaw
  logic signed [P2W-1:0] srcpcy_r, crspsy_r, crspcy_r, srcpsy_r;
  logic signed [P2W-1:0] crcpsy_r, srspcy_r, crcpcy_r, srspsy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      srcpcy_r <= srcp_r * cy_r;
      crspsy_r <= crsp_r * sy_r;
      crspcy_r <= crsp_r * cy_r;
      srcpsy_r <= srcp_r * sy_r;
      crcpsy_r <= crcp_r * sy_r;
      srspcy_r <= srsp_r * cy_r;
      crcpcy_r <= crcp_r * cy_r;
      srspsy_r <= srsp_r * sy_r;
    end
  end

  // Component sums with the rounding half already added
  logic signed [SW-1:0] sx_r, sy_sum_r, sz_r, sw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r     <= SW'(srcpcy_r) - SW'(crspsy_r) + RND;
      sy_sum_r <= SW'(crspcy_r) + SW'(srcpsy_r) + RND;
      sz_r     <= SW'(crcpsy_r) - SW'(srspcy_r) + RND;
      sw_r     <= SW'(crcpcy_r) + SW'(srspsy_r) + RND;
    end
  end

  // Scale to the output format and saturate
  function automatic logic signed [OB-1:0] sat_out(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = s >>> SH;
    if (r > QMAX) begin
      r = QMAX;
    end else if (r < QMIN) begin
      r = QMIN;
    end
    return r[OB-1:0];
  endfunction

  e2q_pkg::quat_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.quat_x = sat_out(sx_r);
    out_nxt.quat_y = sat_out(sy_sum_r);
    out_nxt.quat_z = sat_out(sz_r);
    out_nxt.quat_w = sat_out(sw_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 48;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  e2q_pkg::angle_in_t in_data;
  logic               out_valid;
  logic               out_stall;
  e2q_pkg::quat_out_t out_data;

  e2q_pkg::quat_out_t pending_quats[$];
  int        fail_count;
  int        cycle_count;
  bit        sender_steady;

  // atan(2^-i), 2^32 per full turn
  longint atan_turn [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1
  };

  euler_to_quaternion_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Cosine and sine of half the angle, Q2.15, via 30 CORDIC micro-rotations
  function automatic void half_cos_sin(input logic [15:0] ang,
                                       output longint c, output longint s);
    logic signed [31:0] turn;
    longint x, y, z, dx, dy;
    int i;
    turn = {ang, 16'h0000};
    z = turn;
    z = z >>> 1;
    x = 652032874;
    y = 0;
    for (i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn[i];
      end
    end
    c = clamp_range((x + 16384) >>> 15, -32768, 32768);
    s = clamp_range((y + 16384) >>> 15, -32768, 32768);
  endfunction

  // Q3.45 sum -> Q1.15, round half up, saturate
  function automatic logic [15:0] to_q15(longint sum);
    return 16'(clamp_range((sum + 536870912) >>> 30, -32768, 32767));
  endfunction

  function automatic e2q_pkg::quat_out_t predict_quaternion(e2q_pkg::angle_in_t a);
    longint cr, sr, cp, sp, cy, sy;
    e2q_pkg::quat_out_t q;
    half_cos_sin(a.roll_angle, cr, sr);
    half_cos_sin(a.pitch_angle, cp, sp);
    half_cos_sin(a.yaw_angle, cy, sy);
    q.quat_x = to_q15(sr * cp * cy - cr * sp * sy);
    q.quat_y = to_q15(cr * sp * cy + sr * cp * sy);
    q.quat_z = to_q15(cr * cp * sy - sr * sp * cy);
    q.quat_w = to_q15(cr * cp * cy + sr * sp * sy);
    return q;
  endfunction

  function automatic e2q_pkg::angle_in_t angles(logic [15:0] r, logic [15:0] p,
                                                logic [15:0] y);
    e2q_pkg::angle_in_t a;
    a.roll_angle  = r;
    a.pitch_angle = p;
    a.yaw_angle   = y;
    return a;
  endfunction

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Angle biased toward the interesting points of the circle
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'h4000;
      4: return 16'hC000;
      5: return 16'($urandom_range(0, 15));
      6: return -16'($urandom_range(1, 16));
      7: return 16'h4000 + 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic e2q_pkg::angle_in_t random_attitude();
    if ($urandom_range(0, 9) < 7)
      return angles(16'($urandom), 16'($urandom), 16'($urandom));
    return angles(pick_angle(), pick_angle(), pick_angle());
  endfunction

  // One beat on the input channel; expectation queued at acceptance
  task automatic send_angles(input e2q_pkg::angle_in_t beat, input int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_quats.push_back(predict_quaternion(beat));
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    e2q_pkg::quat_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quats.size() == 0) begin
        $error("result beat %h with nothing pending", out_data);
        fail_count++;
      end else begin
        want = pending_quats.pop_front();
        compare_field("quat_x", want.quat_x, out_data.quat_x);
        compare_field("quat_y", want.quat_y, out_data.quat_y);
        compare_field("quat_z", want.quat_z, out_data.quat_z);
        compare_field("quat_w", want.quat_w, out_data.quat_w);
      end
    end
  end

  // Receiver stall: stretches of none, light, heavy, and long holds
  initial begin
    int mode;
    int run;
    out_stall = 1'b0;
    mode = 0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 9);
        run = (mode == 9) ? $urandom_range(10, 60) : $urandom_range(20, 200);
      end
      run--;
      if (mode < 3)
        out_stall <= 1'b0;
      else if (mode < 7)
        out_stall <= ($urandom_range(0, 7) == 0);
      else if (mode < 9)
        out_stall <= $urandom_range(0, 1);
      else
        out_stall <= 1'b1;
    end
  end

  // Zero attitude (w saturates), half turns, most negative angle, all-ones
  task automatic test_zero_and_extremes();
    send_angles(angles(16'h0000, 16'h0000, 16'h0000), pick_gap());
    send_angles(angles(16'h7FFF, 16'h7FFF, 16'h7FFF), pick_gap());
    send_angles(angles(16'h8000, 16'h8000, 16'h8000), pick_gap());
    send_angles(angles(16'h8000, 16'h0000, 16'h0000), pick_gap());
    send_angles(angles(16'h0000, 16'h8000, 16'h0000), pick_gap());
    send_angles(angles(16'h0000, 16'h0000, 16'h8000), pick_gap());
    send_angles(angles(16'h7FFF, 16'h8000, 16'h0001), pick_gap());
    send_angles(angles(16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap());
  endtask

  // Quarter turns on each axis and mixed octants
  task automatic test_quarter_turns();
    send_angles(angles(16'h4000, 16'h0000, 16'h0000), pick_gap());
    send_angles(angles(16'h0000, 16'h4000, 16'h0000), pick_gap());
    send_angles(angles(16'h0000, 16'h0000, 16'h4000), pick_gap());
    send_angles(angles(16'hC000, 16'hC000, 16'hC000), pick_gap());
    send_angles(angles(16'h4000, 16'h4000, 16'h4000), pick_gap());
    send_angles(angles(16'h2000, 16'hE000, 16'h6000), pick_gap());
  endtask

  task automatic test_bit_patterns();
    send_angles(angles(16'h5555, 16'hAAAA, 16'h0F0F), pick_gap());
    send_angles(angles(16'hAAAA, 16'h5555, 16'hF0F0), pick_gap());
    send_angles(angles(16'h0001, 16'hFFFE, 16'h8001), pick_gap());
  endtask

  // Random attitudes; every so often a stretch with no sender idling
  task automatic test_random_attitudes(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      send_angles(random_attitude(), pick_gap());
    end
    sender_steady = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fail_count = 0;
    cycle_count = 0;
    sender_steady = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_and_extremes();
    test_quarter_turns();
    test_bit_patterns();
    test_random_attitudes(1600);
    drain_results();

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
